// ===== rtl/core/pdac_pkg.sv =====
// pdac_pkg: shared constants, types and helper functions of the palette dac
// used by the controller, the datapath and the top level
// no dependencies
package pdac_pkg;

    // palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    // configuration port
    localparam int CFG_AW = 3;
    localparam logic CFG_IDX_CYCLING = 1'b0;

    // item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_ROTATE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [31:0] RGBA_BLACK   = 32'h0000_00FF;

    // palette entry: red 17:12, green 11:6, blue 5:0
    typedef logic [17:0] entry_t;

    // standard vga colours loaded at reset
    localparam entry_t VGA16 [16] = '{
        {6'd0,  6'd0,  6'd0 }, {6'd0,  6'd0,  6'd42}, {6'd0,  6'd42, 6'd0 },
        {6'd0,  6'd42, 6'd42}, {6'd42, 6'd0,  6'd0 }, {6'd42, 6'd0,  6'd42},
        {6'd42, 6'd21, 6'd0 }, {6'd42, 6'd42, 6'd42}, {6'd21, 6'd21, 6'd21},
        {6'd21, 6'd21, 6'd63}, {6'd21, 6'd63, 6'd21}, {6'd21, 6'd63, 6'd63},
        {6'd63, 6'd21, 6'd21}, {6'd63, 6'd21, 6'd63}, {6'd63, 6'd63, 6'd21},
        {6'd63, 6'd63, 6'd63}
    };

    // controller to datapath commands
    typedef struct packed {
        logic              rd_en;
        logic [PAL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [PAL_AW-1:0] wr_addr;
        logic              wr_carry;
        logic              carry_ld;
        logic              out_ld;
        logic              out_black;
    } pdac_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } pdac_sts_t;

    // entry content after reset
    function automatic entry_t reset_entry(input logic [7:0] idx);
        entry_t e;
        if (idx < 8'd16)
        begin
            e = VGA16[idx[3:0]];
        end
        else
        begin
            e = {idx[5:0], idx[5:0], idx[5:0]};
        end
        return e;
    endfunction

    // 6 to 8 bit expansion by replication
    function automatic logic [7:0] widen(input logic [5:0] c);
        return {c, c[5:4]};
    endfunction

    function automatic logic [31:0] to_rgba(input entry_t e);
        return {widen(e[17:12]), widen(e[11:6]), widen(e[5:0]), ALPHA_OPAQUE};
    endfunction

endpackage

// ===== rtl/core/pdac_if.sv =====
// pdac_in_if, pdac_out_if: valid/ready channels of the palette dac
// input words carry write, rotate and lookup items; output words carry rgba pixels
// no dependencies
interface pdac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] entry_index;
    logic [8:0] range_count;
    logic [5:0] red_in;
    logic [5:0] green_in;
    logic [5:0] blue_in;

    modport source (
        output valid, kind, entry_index, range_count, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, range_count, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface pdac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rgba_pixel;

    modport source (
        output valid, rgba_pixel,
        input  ready
    );
    modport sink (
        input  valid, rgba_pixel,
        output ready
    );
endinterface

// ===== rtl/core/pdac_ctrl.sv =====
// pdac_ctrl: item decode and rotation sequencer of the palette dac
// drives memory and output commands to pdac_dpath; depends on pdac_pkg
module pdac_ctrl
    import pdac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] entry_index,
    input  logic [8:0] range_count,
    input  logic       cycling_enable,
    input  pdac_sts_t  sts,
    output pdac_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROT  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [PAL_AW-1:0] base_reg, base_next;
    logic [8:0]        step_reg, step_next;
    logic [8:0]        count_reg, count_next;
    logic              look_pend_reg, look_pend_next;
    logic              look_black_reg, look_black_next;

    logic       accept;
    logic       idx_ok;
    logic       rot_ok;
    logic [9:0] span;

    // range checks on the incoming word
    assign idx_ok = ({1'b0, entry_index} < 9'(PAL_ENTRIES));
    assign span   = {2'b00, entry_index} + {1'b0, range_count};
    assign rot_ok = cycling_enable && (range_count > 9'd1) && idx_ok
                    && (span <= 10'(PAL_ENTRIES));

    // input stalls during a rotation and while a lookup result cannot move on
    assign in_ready = (state_reg == ST_IDLE) && !(look_pend_reg && sts.out_busy);
    assign accept   = in_valid && in_ready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        look_pend_next  = look_pend_reg;
        look_black_next = look_black_reg;

        cmd           = '0;
        cmd.out_black = look_black_reg;

        // hand a pending lookup to the output register
        if (look_pend_reg && !sts.out_busy)
        begin
            cmd.out_ld     = 1'b1;
            look_pend_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_WRITE:
                        begin
                            cmd.wr_en   = idx_ok;
                            cmd.wr_addr = entry_index[PAL_AW-1:0];
                        end
                        KIND_ROTATE:
                        begin
                            if (rot_ok)
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = entry_index[PAL_AW-1:0];
                                base_next   = entry_index[PAL_AW-1:0];
                                step_next   = 9'd1;
                                count_next  = range_count;
                                state_next  = ST_ROT;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            cmd.rd_en       = idx_ok;
                            cmd.rd_addr     = entry_index[PAL_AW-1:0];
                            look_pend_next  = 1'b1;
                            look_black_next = !idx_ok;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROT:
            begin
                // entry base+step-1 arrives; write the carried entry in its place
                cmd.carry_ld = 1'b1;
                if (step_reg > 9'd1)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_carry = 1'b1;
                    cmd.wr_addr  = PAL_AW'(base_reg + step_reg[PAL_AW-1:0] - PAL_AW'(1));
                end
                if (step_reg < count_reg)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = PAL_AW'(base_reg + step_reg[PAL_AW-1:0]);
                    step_next   = step_reg + 9'd1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // last entry of the range wraps to its start
                cmd.wr_en    = 1'b1;
                cmd.wr_carry = 1'b1;
                cmd.wr_addr  = base_reg;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            look_pend_reg  <= 1'b0;
            look_black_reg <= 1'b0;
            step_reg       <= '0;
            count_reg      <= '0;
            base_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            look_pend_reg  <= look_pend_next;
            look_black_reg <= look_black_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            base_reg       <= base_next;
        end
    end

endmodule

// ===== rtl/core/pdac_dpath.sv =====
// pdac_dpath: palette store, rotation carry and rgba output register
// executes pdac_ctrl commands; depends on pdac_pkg
module pdac_dpath
    import pdac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pdac_cmd_t   cmd,
    input  logic [5:0]  red_in,
    input  logic [5:0]  green_in,
    input  logic [5:0]  blue_in,
    output pdac_sts_t   sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] rgba_pixel
);

    entry_t mem [PAL_ENTRIES];

    logic [PAL_ENTRIES-1:0] written_reg;
    entry_t                 rd_data_reg;
    logic                   rd_written_reg;
    logic [PAL_AW-1:0]      rd_addr_reg;
    entry_t                 carry_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg;

    entry_t wr_data;
    entry_t rd_entry;

    assign wr_data = cmd.wr_carry ? carry_reg : {red_in, green_in, blue_in};

    // entries never written since reset read as their reset colour
    assign rd_entry = rd_written_reg ? rd_data_reg : reset_entry(8'(rd_addr_reg));

    // palette store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
            rd_addr_reg <= cmd.rd_addr;
        end
    end

    // written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                written_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_written_reg <= written_reg[cmd.rd_addr];
            end
        end
    end

    // rotation carry and output data
    always_ff @(posedge clk)
    begin
        if (cmd.carry_ld)
        begin
            carry_reg <= rd_entry;
        end
        if (cmd.out_ld)
        begin
            out_data_reg <= cmd.out_black ? RGBA_BLACK : to_rgba(rd_entry);
        end
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign rgba_pixel   = out_data_reg;

endmodule

// ===== rtl/core/palette_dac_with_rotation.sv =====
// palette_dac_with_rotation: 256-entry palette with range rotation and rgba lookup
// top level; depends on pdac_pkg, pdac_if, pdac_ctrl, pdac_dpath
//
// usage
//   in_ch carries one word per item: write an entry, rotate a range right by
//   one, or look up a pixel. only lookups produce a word on out_ch, as rgba8888
//   with 6 to 8 bit replicated components and alpha 0xff.
//   the apb port holds cycling_enable at address 0; rotations are dropped
//   while it is clear. write it only while the block is idle.
// flow
//   a lookup result passes the store read register and then the output register
//   on its way to out_ch; lookups stream at one per cycle while out_ch takes them.
//   a rotation holds in_ch.ready low from acceptance until it is done, set by
//   the single read and single write port of the store.
// reset
//   the store reads as the 16 vga colours followed by a grey ramp that repeats
//   every 64 entries, at once; per-entry written flags select between stored
//   and reset colours, so no clearing pass is needed. cycling_enable resets to 0.
// stalls
//   one result waits in the output register; while it is held and another
//   lookup result is pending, in_ch.ready stays low.
module palette_dac_with_rotation
    import pdac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    pdac_in_if.sink           in_ch,
    pdac_out_if.source        out_ch
);

    logic      cycling_reg, cycling_next;
    logic      cfg_wr;
    pdac_cmd_t cmd;
    pdac_sts_t sts;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CYCLING);

    always_comb
    begin
        cycling_next = cycling_reg;
        if (cfg_wr)
        begin
            cycling_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycling_reg <= 1'b0;
        end
        else
        begin
            cycling_reg <= cycling_next;
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_CYCLING) ? {31'd0, cycling_reg} : 32'd0;

    // controller
    pdac_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .kind           (in_ch.kind),
        .entry_index    (in_ch.entry_index),
        .range_count    (in_ch.range_count),
        .cycling_enable (cycling_reg),
        .sts            (sts),
        .cmd            (cmd)
    );

    // datapath
    pdac_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .red_in     (in_ch.red_in),
        .green_in   (in_ch.green_in),
        .blue_in    (in_ch.blue_in),
        .sts        (sts),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .rgba_pixel (out_ch.rgba_pixel)
    );

    // a taken lookup moves to the output next cycle unless input is held off
    a_lookup_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.kind == KIND_LOOKUP))
        |=> (cmd.out_ld || !in_ch.ready))
        else $error("lookup result neither loaded nor input stalled");

    // single store port pair never collides on one address
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
        else $error("store read and write on the same address");

    // a rotation with cycling disabled never starts the sequencer
    a_rotate_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.kind == KIND_ROTATE) && !cycling_reg)
        |=> !cmd.carry_ld)
        else $error("rotation started while cycling disabled");

endmodule

// ===== verif/tb_palette_dac_with_rotation.sv =====
// tb_palette_dac_with_rotation: self-checking testbench of the palette dac with range rotation
// predicts every lookup word from its own palette copy; depends on pdac_pkg, pdac_if and the rtl
`timescale 1ns / 100ps

module tb_palette_dac_with_rotation;
    import pdac_pkg::*;

    localparam logic [1:0]        KIND_UNUSED   = 2'd3;
    localparam logic [CFG_AW-1:0] CYCLING_ADDR  = CFG_AW'(4 * int'(CFG_IDX_CYCLING));
    // long enough for a full-table rotation to release the input
    localparam int                ROT_SETTLE    = PAL_ENTRIES + 8;
    localparam int                HOLD_OFF      = 400;
    localparam int                WATCHDOG_LIMIT = 4000;

    // reset colors of the first sixteen entries
    localparam entry_t BASE_COLORS [16] = '{
        {6'd0,  6'd0,  6'd0 }, {6'd0,  6'd0,  6'd42}, {6'd0,  6'd42, 6'd0 },
        {6'd0,  6'd42, 6'd42}, {6'd42, 6'd0,  6'd0 }, {6'd42, 6'd0,  6'd42},
        {6'd42, 6'd21, 6'd0 }, {6'd42, 6'd42, 6'd42}, {6'd21, 6'd21, 6'd21},
        {6'd21, 6'd21, 6'd63}, {6'd21, 6'd63, 6'd21}, {6'd21, 6'd63, 6'd63},
        {6'd63, 6'd21, 6'd21}, {6'd63, 6'd21, 6'd63}, {6'd63, 6'd63, 6'd21},
        {6'd63, 6'd63, 6'd63}
    };

    typedef struct {
        logic [1:0] kind;
        logic [7:0] entry;
        logic [8:0] span;
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } palette_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pdac_in_if  in_ch ();
    pdac_out_if out_ch ();

    palette_dac_with_rotation dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // predicted palette and register
    entry_t      palette_copy [PAL_ENTRIES];
    logic        cycling_on;
    logic [31:0] pixel_expect [$];

    int          fail_count = 0;
    bit          src_idle_on = 1'b1;
    bit          snk_idle_on = 1'b1;
    int unsigned sink_hold = 0;
    int unsigned quiet_cycles = 0;
    logic [31:0] pixel_want;

    always #2 clk = ~clk;

    // 6 to 8 bit component expansion
    function automatic logic [7:0] stretch6(input logic [5:0] c);
        return {c, c[5:4]};
    endfunction

    function automatic logic [31:0] rgba_of(input entry_t e);
        return {stretch6(e[17:12]), stretch6(e[11:6]), stretch6(e[5:0]), ALPHA_OPAQUE};
    endfunction

    function automatic void palette_reset();
        logic [5:0] grey;
        for (int i = 0; i < PAL_ENTRIES; i++)
        begin
            grey = 6'(i % 64);
            palette_copy[i] = (i < 16) ? BASE_COLORS[i] : {grey, grey, grey};
        end
        cycling_on = 1'b0;
    endfunction

    // apply one accepted word to the palette copy
    function automatic void palette_apply(input palette_cmd_t w);
        entry_t last;
        int     first;
        int     n;
        first = int'(w.entry);
        n     = int'(w.span);
        case (w.kind)
            KIND_WRITE:
                palette_copy[first] = {w.red, w.green, w.blue};
            KIND_ROTATE:
                if (cycling_on && n > 1 && n <= PAL_ENTRIES - first)
                begin
                    last = palette_copy[first + n - 1];
                    for (int i = n - 1; i > 0; i--)
                        palette_copy[first + i] = palette_copy[first + i - 1];
                    palette_copy[first] = last;
                end
            KIND_LOOKUP:
                pixel_expect.push_back(rgba_of(palette_copy[first]));
            default:
                ;
        endcase
    endfunction

    function automatic palette_cmd_t make_word(input logic [1:0] kind, input int entry,
                                               input int span, input logic [5:0] red,
                                               input logic [5:0] green, input logic [5:0] blue);
        palette_cmd_t w;
        w.kind  = kind;
        w.entry = 8'(entry);
        w.span  = 9'(span);
        w.red   = red;
        w.green = green;
        w.blue  = blue;
        return w;
    endfunction

    // mostly lookups and writes, rotations mostly short and in range
    function automatic palette_cmd_t random_word();
        palette_cmd_t w;
        int unsigned  pick;
        int unsigned  room;
        int unsigned  shape;
        w.entry = 8'($urandom_range(0, 255));
        w.span  = 9'($urandom_range(0, 511));
        w.red   = 6'($urandom_range(0, 63));
        w.green = 6'($urandom_range(0, 63));
        w.blue  = 6'($urandom_range(0, 63));
        pick    = $urandom_range(0, 99);
        room    = PAL_ENTRIES - w.entry;
        if (pick < 55)
            w.kind = KIND_LOOKUP;
        else if (pick < 80)
            w.kind = KIND_WRITE;
        else if (pick < 96)
        begin
            w.kind = KIND_ROTATE;
            shape  = $urandom_range(0, 19);
            if (shape < 14 && room >= 2)
                w.span = 9'($urandom_range(2, (room < 8) ? room : 8));
            else if (shape == 14)
                w.span = 9'(room);
            else if (shape < 18)
                w.span = 9'($urandom_range(0, 1));
        end
        else
            w.kind = KIND_UNUSED;
        return w;
    endfunction

    // offer one word and wait for it to be taken; entered and left at a falling edge
    task automatic send_word(input palette_cmd_t w);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= w.kind;
        in_ch.entry_index <= w.entry;
        in_ch.range_count <= w.span;
        in_ch.red_in      <= w.red;
        in_ch.green_in    <= w.green;
        in_ch.blue_in     <= w.blue;
        do @(posedge clk); while (!in_ch.ready);
        palette_apply(w);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pixel_expect.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // apb write of cycling_enable, then read it back
    task automatic write_cycling(input logic [31:0] value);
        drain_results();
        repeat (ROT_SETTLE) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CYCLING_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cycling_on = value[0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {31'd0, cycling_on})
        begin
            $error("cycling_enable: expected %h, got %h", {31'd0, cycling_on}, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_colors();
        int picks [6] = '{0, 6, 9, 15, 16, 255};
        foreach (picks[i])
            send_word(make_word(KIND_LOOKUP, picks[i], 0, 6'd0, 6'd0, 6'd0));
    endtask

    task automatic test_entry_writes();
        send_word(make_word(KIND_WRITE, 0, 0, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_WRITE, 255, 511, 6'd63, 6'd63, 6'd63));
        send_word(make_word(KIND_WRITE, 128, 0, 6'd42, 6'd21, 6'd63));
        send_word(make_word(KIND_LOOKUP, 128, 0, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_LOOKUP, 255, 0, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_LOOKUP, 0, 0, 6'd0, 6'd0, 6'd0));
    endtask

    task automatic test_unused_kind();
        send_word(make_word(KIND_UNUSED, 5, 4, 6'd63, 6'd63, 6'd63));
        send_word(make_word(KIND_LOOKUP, 5, 0, 6'd0, 6'd0, 6'd0));
    endtask

    // cycling is clear after reset, so the rotation must be dropped
    task automatic test_rotate_disabled();
        send_word(make_word(KIND_ROTATE, 0, 16, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_LOOKUP, 0, 0, 6'd0, 6'd0, 6'd0));
    endtask

    task automatic test_rotate_edges();
        send_word(make_word(KIND_ROTATE, 10, 0, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_ROTATE, 10, 1, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_ROTATE, 255, 2, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_ROTATE, 0, 511, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_ROTATE, 0, PAL_ENTRIES, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_ROTATE, 254, 2, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_LOOKUP, 0, 0, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_LOOKUP, 254, 0, 6'd0, 6'd0, 6'd0));
        send_word(make_word(KIND_LOOKUP, 255, 0, 6'd0, 6'd0, 6'd0));
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_word(random_word());
    endtask

    // receiver holds off while lookups keep coming, then the sender waits for all results
    task automatic test_output_backpressure();
        sink_hold = HOLD_OFF;
        repeat (40)
            send_word(make_word(KIND_LOOKUP, $urandom_range(0, 255), 0, 6'd0, 6'd0, 6'd0));
        drain_results();
    endtask

    // receiver side: random stalls, and a long hold-off on request
    initial
    begin : result_sink
        int unsigned stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (sink_hold != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold) @(negedge clk);
                sink_hold = 0;
            end
            stall = snk_idle_on ? $urandom_range(0, 15) : 0;
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // compare every taken word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pixel_expect.size() == 0)
            begin
                $error("rgba_pixel: expected none, got %h", out_ch.rgba_pixel);
                fail_count++;
            end
            else
            begin
                pixel_want = pixel_expect.pop_front();
                if (out_ch.rgba_pixel !== pixel_want)
                begin
                    $error("rgba_pixel: expected %h, got %h", pixel_want, out_ch.rgba_pixel);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_WRITE;
        in_ch.entry_index = '0;
        in_ch.range_count = '0;
        in_ch.red_in      = '0;
        in_ch.green_in    = '0;
        in_ch.blue_in     = '0;
        palette_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        test_reset_colors();
        test_entry_writes();
        test_unused_kind();
        test_rotate_disabled();
        write_cycling(32'hFFFF_FFFF);
        test_rotate_edges();

        // random part, cycling on, both sides idling
        test_random_mix(350);

        // cycling off, full-rate streaming
        write_cycling(32'h0000_0000);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        test_random_mix(250);

        write_cycling(32'hFFFF_FFFE);
        snk_idle_on = 1'b1;
        test_output_backpressure();

        // cycling back on, one side idling at a time
        write_cycling(32'h0000_0001);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b0;
        test_random_mix(190);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        test_random_mix(190);

        drain_results();
        repeat (ROT_SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
